[src/ktt_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the keyed track table.
package ktt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 4;
    localparam int KEY_W       = 32;
    localparam int POS_W       = 16;
    localparam int TS_W        = 32;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 3;
    localparam int RESULT_CAP  = 16;
    localparam int NREP_W      = $clog2(RESULT_CAP + 1);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [TS_W-1:0] EXPIRE_RESET = 32'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_SWEEP  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_UPDATED  = 3'd1,
        STAT_DROPPED  = 3'd2,
        STAT_EXPIRED  = 3'd3,
        STAT_NONE     = 3'd4,
        STAT_READ     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_WRITE,
        S_SWEEP,
        S_FLUSH,
        S_READ
    } t_state;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
        logic [POS_W-1:0]        ext;
        logic [TS_W-1:0]         ts;
        logic [IDX_W-1:0]        rs;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_req;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
        logic [POS_W-1:0]        ext;
        logic [TS_W-1:0]         stamp;
    } t_entry;

    typedef struct packed {
        t_status                 status;
        logic [IDX_W-1:0]        slot;
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        x;
        logic [POS_W-1:0]        y;
        logic [POS_W-1:0]        ext;
        logic                    last;
    } t_res;

endpackage

[src/ktt_front.sv]
`timescale 1ns / 1ps
// Input stage: accepts items, drops unused opcodes, queues commands for the back end.
module ktt_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ktt_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [ktt_pkg::KEY_W-1:0]  i_object_key,
    input  logic [ktt_pkg::POS_W-1:0]         i_pos_x,
    input  logic [ktt_pkg::POS_W-1:0]         i_pos_y,
    input  logic [ktt_pkg::POS_W-1:0]         i_extent,
    input  logic [ktt_pkg::TS_W-1:0]          i_timestamp,
    input  logic [ktt_pkg::IDX_W-1:0]         i_read_slot,
    input  logic                              i_take,
    output ktt_pkg::t_req                     o_req
);

    ktt_pkg::t_cmd                r_fifo [ktt_pkg::QDEPTH];
    logic [ktt_pkg::QPTR_W-1:0]   r_wr;
    logic [ktt_pkg::QPTR_W-1:0]   r_rd;
    logic [ktt_pkg::QCNT_W-1:0]   r_cnt;
    logic [ktt_pkg::QPTR_W-1:0]   n_wr;
    logic [ktt_pkg::QPTR_W-1:0]   n_rd;
    logic [ktt_pkg::QCNT_W-1:0]   n_cnt;
    logic                         push;
    logic                         pop;
    ktt_pkg::t_cmd                cmd;

    assign o_stall = (r_cnt == ktt_pkg::QCNT_W'(ktt_pkg::QDEPTH));
    assign push    = i_valid && !o_stall && (ktt_pkg::t_op'(i_opcode) != ktt_pkg::OP_NOP);
    assign pop     = i_take && (r_cnt != '0);

    always_comb begin
        cmd.op  = ktt_pkg::t_op'(i_opcode);
        cmd.key = i_object_key;
        cmd.x   = i_pos_x;
        cmd.y   = i_pos_y;
        cmd.ext = i_extent;
        cmd.ts  = i_timestamp;
        cmd.rs  = i_read_slot;
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == ktt_pkg::QPTR_W'(ktt_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == ktt_pkg::QPTR_W'(ktt_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr] <= cmd;
        end
    end

    assign o_req.valid = (r_cnt != '0);
    assign o_req.cmd   = r_fifo[r_rd];

endmodule

[src/ktt_back.sv]
`timescale 1ns / 1ps
// Back end: slot memory, live bits, scan sequencer and result register.
module ktt_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ktt_pkg::t_req            i_req,
    output logic                     o_take,
    input  logic [ktt_pkg::TS_W-1:0] i_limit,
    output logic                     o_valid,
    input  logic                     i_stall,
    output ktt_pkg::t_res            o_res
);

    ktt_pkg::t_state                 r_state;
    ktt_pkg::t_state                 n_state;
    ktt_pkg::t_cmd                   r_cmd;
    logic [ktt_pkg::SLOT_W-1:0]      r_idx;
    logic                            r_primed;
    logic                            r_hit;
    logic [ktt_pkg::TABLE_DEPTH-1:0] r_live;
    logic                            r_pend_v;
    ktt_pkg::t_res                   r_pend;
    logic [ktt_pkg::NREP_W-1:0]      r_nrep;
    ktt_pkg::t_entry                 r_mem [ktt_pkg::TABLE_DEPTH];
    ktt_pkg::t_entry                 r_q;
    logic                            r_ov;
    ktt_pkg::t_res                   r_res;

    logic                            out_free;
    logic                            last_idx;
    logic [ktt_pkg::TS_W-1:0]        age;
    logic                            expired;
    logic                            key_hit;
    logic                            can_rep;
    logic                            rs_ok;
    logic [ktt_pkg::SLOT_W-1:0]      rd_slot;
    logic                            free_v;
    logic [ktt_pkg::SLOT_W-1:0]      free_idx;

    logic [ktt_pkg::SLOT_W-1:0]      rd_addr;
    logic                            step;
    logic                            hit_found;
    logic                            live_clr;
    logic                            live_set;
    logic [ktt_pkg::SLOT_W-1:0]      set_idx;
    logic                            mem_we;
    logic                            pend_load;
    logic                            emit;
    ktt_pkg::t_res                   emit_res;
    ktt_pkg::t_entry                 wentry;
    ktt_pkg::t_res                   pend_res;

    assign out_free = !r_ov || !i_stall;
    assign last_idx = (r_idx == ktt_pkg::SLOT_W'(ktt_pkg::TABLE_DEPTH - 1));
    assign age      = r_cmd.ts - r_q.stamp;
    assign expired  = r_live[r_idx] && (age > i_limit);
    assign key_hit  = r_live[r_idx] && (r_q.key == r_cmd.key);
    assign can_rep  = (r_nrep < ktt_pkg::NREP_W'(ktt_pkg::RESULT_CAP));
    assign rs_ok    = (int'(r_cmd.rs) < ktt_pkg::TABLE_DEPTH);
    assign rd_slot  = rs_ok ? ktt_pkg::SLOT_W'(r_cmd.rs) : '0;
    assign free_v   = ~&r_live;

    always_comb begin
        free_idx = '0;
        for (int i = ktt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                free_idx = ktt_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb begin
        wentry.key   = r_cmd.key;
        wentry.x     = r_cmd.x;
        wentry.y     = r_cmd.y;
        wentry.ext   = r_cmd.ext;
        wentry.stamp = r_cmd.ts;
    end

    always_comb begin
        pend_res.status = ktt_pkg::STAT_EXPIRED;
        pend_res.slot   = ktt_pkg::IDX_W'(r_idx);
        pend_res.valid  = 1'b0;
        pend_res.key    = r_q.key;
        pend_res.x      = r_q.x;
        pend_res.y      = r_q.y;
        pend_res.ext    = r_q.ext;
        pend_res.last   = 1'b0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ktt_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.cmd.op)
                        ktt_pkg::OP_UPDATE: n_state = ktt_pkg::S_UPD;
                        ktt_pkg::OP_SWEEP:  n_state = ktt_pkg::S_SWEEP;
                        ktt_pkg::OP_READ:   n_state = ktt_pkg::S_READ;
                        default:            n_state = ktt_pkg::S_IDLE;
                    endcase
                end
            end
            ktt_pkg::S_UPD: begin
                if (r_primed && (key_hit || last_idx)) begin
                    n_state = ktt_pkg::S_WRITE;
                end
            end
            ktt_pkg::S_WRITE: begin
                if (out_free) begin
                    n_state = ktt_pkg::S_IDLE;
                end
            end
            ktt_pkg::S_SWEEP: begin
                if (step && last_idx) begin
                    n_state = ktt_pkg::S_FLUSH;
                end
            end
            ktt_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_state = ktt_pkg::S_IDLE;
                end
            end
            ktt_pkg::S_READ: begin
                if (r_primed && out_free) begin
                    n_state = ktt_pkg::S_IDLE;
                end
            end
            default: n_state = ktt_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_take    = 1'b0;
        rd_addr   = r_idx;
        step      = 1'b0;
        hit_found = 1'b0;
        live_clr  = 1'b0;
        live_set  = 1'b0;
        set_idx   = r_idx;
        mem_we    = 1'b0;
        pend_load = 1'b0;
        emit      = 1'b0;
        emit_res  = '0;
        case (r_state)
            ktt_pkg::S_IDLE: begin
                o_take  = i_req.valid;
                rd_addr = '0;
            end
            ktt_pkg::S_UPD: begin
                if (r_primed) begin
                    if (key_hit) begin
                        hit_found = 1'b1;
                    end else begin
                        step = 1'b1;
                        if (!last_idx) begin
                            rd_addr = r_idx + 1'b1;
                        end
                    end
                end
            end
            ktt_pkg::S_WRITE: begin
                emit_res.key  = r_cmd.key;
                emit_res.x    = r_cmd.x;
                emit_res.y    = r_cmd.y;
                emit_res.ext  = r_cmd.ext;
                emit_res.last = 1'b1;
                if (r_hit) begin
                    emit_res.status = ktt_pkg::STAT_UPDATED;
                    emit_res.slot   = ktt_pkg::IDX_W'(r_idx);
                    emit_res.valid  = 1'b1;
                    set_idx         = r_idx;
                end else if (free_v) begin
                    emit_res.status = ktt_pkg::STAT_INSERTED;
                    emit_res.slot   = ktt_pkg::IDX_W'(free_idx);
                    emit_res.valid  = 1'b1;
                    set_idx         = free_idx;
                end else begin
                    emit_res.status = ktt_pkg::STAT_DROPPED;
                end
                if (out_free) begin
                    emit     = 1'b1;
                    mem_we   = r_hit || free_v;
                    live_set = r_hit || free_v;
                end
            end
            ktt_pkg::S_SWEEP: begin
                if (r_primed && !(expired && can_rep && r_pend_v && !out_free)) begin
                    step = 1'b1;
                    if (!last_idx) begin
                        rd_addr = r_idx + 1'b1;
                    end
                    if (expired) begin
                        live_clr = 1'b1;
                        if (can_rep) begin
                            pend_load = 1'b1;
                            emit      = r_pend_v;
                            emit_res  = r_pend;
                        end
                    end
                end
            end
            ktt_pkg::S_FLUSH: begin
                emit = out_free;
                if (r_pend_v) begin
                    emit_res      = r_pend;
                    emit_res.last = 1'b1;
                end else begin
                    emit_res.status = ktt_pkg::STAT_NONE;
                    emit_res.last   = 1'b1;
                end
            end
            ktt_pkg::S_READ: begin
                rd_addr          = rd_slot;
                emit             = r_primed && out_free;
                emit_res.status  = ktt_pkg::STAT_READ;
                emit_res.slot    = r_cmd.rs;
                emit_res.last    = 1'b1;
                if (rs_ok) begin
                    emit_res.valid = r_live[rd_slot];
                    emit_res.key   = r_q.key;
                    emit_res.x     = r_q.x;
                    emit_res.y     = r_q.y;
                    emit_res.ext   = r_q.ext;
                end
            end
            default: begin
                o_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ktt_pkg::S_IDLE;
            r_idx    <= '0;
            r_primed <= 1'b0;
            r_hit    <= 1'b0;
            r_live   <= '0;
            r_pend_v <= 1'b0;
            r_nrep   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_primed <= (r_state inside {ktt_pkg::S_UPD, ktt_pkg::S_SWEEP, ktt_pkg::S_READ});
            if (o_take) begin
                r_idx    <= '0;
                r_hit    <= 1'b0;
                r_pend_v <= 1'b0;
                r_nrep   <= '0;
            end else begin
                if (step) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (hit_found) begin
                    r_hit <= 1'b1;
                end
                if (pend_load) begin
                    r_pend_v <= 1'b1;
                    r_nrep   <= r_nrep + 1'b1;
                end
            end
            if (live_clr) begin
                r_live[r_idx] <= 1'b0;
            end
            if (live_set) begin
                r_live[set_idx] <= 1'b1;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cmd <= i_req.cmd;
        end
        if (pend_load) begin
            r_pend <= pend_res;
        end
        if (emit) begin
            r_res <= emit_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[set_idx] <= wentry;
        end
        r_q <= r_mem[rd_addr];
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

[src/keyed_track_table_with_aging_unit.sv]
`timescale 1ns / 1ps
// Top level of the keyed track table with entry aging.
//
// Input channel (i_valid / o_stall): one command per transfer. Opcode 0 looks
// up i_object_key and updates or inserts that entry (dropped when full), opcode 1 removes every
// live entry older than the expire limit at time i_timestamp, opcode 2 reads
// slot i_read_slot, opcode 3 is discarded without a result.
// Output channel (o_valid / i_stall): one result per transfer, o_last_result
// marks the final result of a command. A sweep gives one result per removed
// slot in ascending order, or one "none expired" result.
// Config channel (i_cfg_valid / o_cfg_ready): writes the expire limit; ready
// is always high. Write only while the block is idle.
// Timing: a two-deep command queue feeds a sequencer that walks the slot
// memory one slot per cycle through its single registered read port; a sweep
// holds its walk while a result waits on a stalled output. An update stops
// at the first slot whose key matches or at the last slot, a sweep walks
// every slot, and a read fetches the one slot it names.
// Reset clears all live bits and the queue and loads the limit with 1000.
// A stalled receiver holds the result register; the sequencer waits once it
// has a result to hand over, while the queue keeps taking commands until full.
module keyed_track_table_with_aging_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ktt_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [ktt_pkg::KEY_W-1:0]  i_object_key,
    input  logic [ktt_pkg::POS_W-1:0]         i_pos_x,
    input  logic [ktt_pkg::POS_W-1:0]         i_pos_y,
    input  logic [ktt_pkg::POS_W-1:0]         i_extent,
    input  logic [ktt_pkg::TS_W-1:0]          i_timestamp,
    input  logic [ktt_pkg::IDX_W-1:0]         i_read_slot,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ktt_pkg::STAT_W-1:0]        o_status,
    output logic [ktt_pkg::IDX_W-1:0]         o_slot_index,
    output logic                              o_entry_valid,
    output logic signed [ktt_pkg::KEY_W-1:0]  o_entry_key,
    output logic [ktt_pkg::POS_W-1:0]         o_entry_x,
    output logic [ktt_pkg::POS_W-1:0]         o_entry_y,
    output logic [ktt_pkg::POS_W-1:0]         o_entry_extent,
    output logic                              o_last_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ktt_pkg::TS_W-1:0]          i_cfg_data
);

    logic [ktt_pkg::TS_W-1:0] r_expire_limit;
    ktt_pkg::t_req            req;
    logic                     take;
    ktt_pkg::t_res            res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire_limit <= ktt_pkg::EXPIRE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_expire_limit <= i_cfg_data;
        end
    end

    ktt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_object_key (i_object_key),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_extent     (i_extent),
        .i_timestamp  (i_timestamp),
        .i_read_slot  (i_read_slot),
        .i_take       (take),
        .o_req        (req)
    );

    ktt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_take  (take),
        .i_limit (r_expire_limit),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    assign o_status       = res.status;
    assign o_slot_index   = res.slot;
    assign o_entry_valid  = res.valid;
    assign o_entry_key    = res.key;
    assign o_entry_x      = res.x;
    assign o_entry_y      = res.y;
    assign o_entry_extent = res.ext;
    assign o_last_result  = res.last;

endmodule

[src/ktt_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the track table top level, with its bind.
module ktt_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic [ktt_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [ktt_pkg::KEY_W-1:0]  i_object_key,
    input  logic [ktt_pkg::POS_W-1:0]         i_pos_x,
    input  logic [ktt_pkg::POS_W-1:0]         i_pos_y,
    input  logic [ktt_pkg::POS_W-1:0]         i_extent,
    input  logic [ktt_pkg::TS_W-1:0]          i_timestamp,
    input  logic [ktt_pkg::IDX_W-1:0]         i_read_slot,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [ktt_pkg::STAT_W-1:0]        o_status,
    input  logic [ktt_pkg::IDX_W-1:0]         o_slot_index,
    input  logic                              o_entry_valid,
    input  logic signed [ktt_pkg::KEY_W-1:0]  o_entry_key,
    input  logic [ktt_pkg::POS_W-1:0]         o_entry_x,
    input  logic [ktt_pkg::POS_W-1:0]         o_entry_y,
    input  logic [ktt_pkg::POS_W-1:0]         o_entry_extent,
    input  logic                              o_last_result,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [ktt_pkg::TS_W-1:0]          i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_slot_index)
            && $stable(o_entry_key) && $stable(o_last_result))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("channels active after reset");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ktt_pkg::STAT_INSERTED || o_status == ktt_pkg::STAT_UPDATED)
            |-> o_entry_valid && o_last_result)
        else $error("update transfer not live or not last");

    a_removed_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ktt_pkg::STAT_EXPIRED || o_status == ktt_pkg::STAT_DROPPED
            || o_status == ktt_pkg::STAT_NONE) |-> !o_entry_valid)
        else $error("removed or rejected entry reported live");

    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ktt_pkg::STAT_NONE
            |-> o_last_result && o_slot_index == '0 && o_entry_key == '0)
        else $error("none-expired transfer not empty");

endmodule

bind keyed_track_table_with_aging_unit ktt_checker u_ktt_checker (.*);
